// File: hdl/ttok_pkg.sv
// Shared types, constants and helpers for the text tokenizer.
`default_nettype none
package ttok_pkg;

  localparam int POS_WIDTH = 16;
  localparam int LEN_WIDTH = POS_WIDTH + 1;
  localparam int OUT_WIDTH = 16;
  localparam int OUT_MAX   = (1 << OUT_WIDTH) - 1;
  localparam int CLAMP_W   = (LEN_WIDTH > OUT_WIDTH) ? LEN_WIDTH : OUT_WIDTH;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_NUM     = 3'd1;
  localparam logic [2:0] KIND_OP      = 3'd2;
  localparam logic [2:0] KIND_BRACKET = 3'd3;
  localparam logic [2:0] KIND_QUOTED  = 3'd4;
  localparam logic [2:0] KIND_EMPTY   = 3'd5;

  typedef struct packed {
    logic [2:0]           kind;
    logic [OUT_WIDTH-1:0] start;
    logic [OUT_WIDTH-1:0] length;
    logic                 closed;
  } tok_t;

  // One queue entry: the results caused by one input word.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

  function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic [LEN_WIDTH-1:0] v);
    logic [CLAMP_W-1:0] w;
    w = CLAMP_W'(v);
    if (w > CLAMP_W'(OUT_MAX)) begin
      return OUT_WIDTH'(OUT_MAX);
    end
    return OUT_WIDTH'(w);
  endfunction

endpackage
`default_nettype wire

// File: hdl/text_tokenizer_unit.sv
// Text tokenizer top level: scanner front end feeding a token queue.
// Each token passes through the queue and then the output register before it appears on the out_ ports.
// Throughput: one text byte per cycle while in_stall is low; output is one token per cycle
// while out_stall is low, so a byte that yields two tokens is sent one token at a time, absorbed by the 4-entry queue.
// in_stall rises only while the queue is full.
// Reset (rst_n low, synchronous) empties the queue and returns the scanner to idle at offset 0.
`default_nettype none
module text_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_text_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_token_kind,
  output      logic [15:0] out_token_start,
  output      logic [15:0] out_token_length,
  output      logic        out_quote_closed,
  output      logic        out_last_of_input
);

  logic           accept;
  logic           push;
  logic           full;
  ttok_pkg::rec_t rec;
  ttok_pkg::tok_t tok;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ttok_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_text_byte),
    .push      (push),
    .rec       (rec)
  );

  ttok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rec       (rec),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (tok),
    .out_last  (out_last_of_input)
  );

  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.length;
  assign out_quote_closed = tok.closed;

endmodule
`default_nettype wire

// File: hdl/ttok_front.sv
// Front end: per-byte scanner state machine, builds result records.
`default_nettype none
module ttok_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          text_byte,
  output      logic                push,
  output      ttok_pkg::rec_t      rec
);

  localparam int PW = ttok_pkg::POS_WIDTH;
  localparam int LW = ttok_pkg::LEN_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_QUOTE   = 4'd1;
  localparam logic [3:0] M_SIGN    = 4'd2;
  localparam logic [3:0] M_SIGNDOT = 4'd3;
  localparam logic [3:0] M_DOT     = 4'd4;
  localparam logic [3:0] M_OP      = 4'd5;
  localparam logic [3:0] M_INT     = 4'd6;
  localparam logic [3:0] M_FRAC    = 4'd7;
  localparam logic [3:0] M_EXP     = 4'd8;
  localparam logic [3:0] M_IDENT   = 4'd9;

  typedef struct packed {
    logic [3:0]    mode;
    logic          qsel;
    logic          qsingle;
    logic [PW-1:0] tstart;
    logic          emit;
    logic [2:0]    kind;
  } start_t;

  logic [3:0]    mode_r, mode_nxt;
  logic          qsingle_r, qsingle_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] tstart_r, tstart_nxt;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0D || c == 8'h0A || c == 8'h0B || c == 8'h09;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == "[" || c == "]" || c == "{" || c == "}" || c == "(" || c == ")";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "!" || c == "#" || c == "$" || c == "%" || c == "&" || c == "*" ||
           c == "+" || c == "-" || c == "." || c == ":" || c == ";" || c == "<" ||
           c == "=" || c == ">" || c == "@" || c == "|" || c == "~";
  endfunction

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] p);
    return (p == POS_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] span(input logic [PW-1:0] p, input logic [PW-1:0] s);
    return (p >= s) ? p - s : '0;
  endfunction

  function automatic logic [2:0] kind_of_mode(input logic [3:0] m);
    if (m == M_QUOTE) return ttok_pkg::KIND_QUOTED;
    if (m == M_INT || m == M_FRAC || m == M_EXP) return ttok_pkg::KIND_NUM;
    if (m == M_IDENT) return ttok_pkg::KIND_IDENT;
    return ttok_pkg::KIND_OP;
  endfunction

  function automatic ttok_pkg::tok_t mk_tok(input logic [2:0] k, input logic [PW-1:0] s,
                                            input logic [LW-1:0] len, input logic cl);
    ttok_pkg::tok_t t;
    t.kind   = k;
    t.start  = ttok_pkg::clamp_out({1'b0, s});
    t.length = ttok_pkg::clamp_out(len);
    t.closed = cl;
    return t;
  endfunction

  // First byte of a new token.
  function automatic start_t start_token(input logic [7:0] c, input logic [PW-1:0] p);
    start_t r;
    r.mode    = M_IDLE;
    r.qsel    = 1'b0;
    r.qsingle = 1'b0;
    r.tstart  = p;
    r.emit    = 1'b0;
    r.kind    = ttok_pkg::KIND_EMPTY;
    if (is_blank(c)) begin
      r.tstart = '0;
    end else if (c == 8'h22 || c == 8'h27) begin
      r.mode    = M_QUOTE;
      r.qsel    = 1'b1;
      r.qsingle = (c == 8'h27);
      r.tstart  = sat_inc(p);
    end else if (is_op(c)) begin
      r.mode = (c == "+" || c == "-") ? M_SIGN : (c == ".") ? M_DOT : M_OP;
    end else if (is_digit(c)) begin
      r.mode = M_INT;
    end else if (is_alpha(c) || c == "_") begin
      r.mode = M_IDENT;
    end else if (is_bracket(c)) begin
      r.emit = 1'b1;
      r.kind = ttok_pkg::KIND_BRACKET;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  logic            end_prev;
  logic            v0, v1;
  logic [PW-1:0]   cur_span;
  start_t          st;

  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    pos_nxt     = pos_r;
    tstart_nxt  = tstart_r;
    end_prev    = 1'b0;
    v0          = 1'b0;
    v1          = 1'b0;
    cur_span    = span(pos_r, tstart_r);
    rec         = '0;
    st          = start_token(text_byte, pos_r);

    if (text_byte == 8'h00) begin
      if (mode_r != M_IDLE) begin
        v0       = 1'b1;
        rec.tok0 = mk_tok(kind_of_mode(mode_r), tstart_r, {1'b0, cur_span}, 1'b0);
      end
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
    end else begin
      unique case (mode_r)
        M_QUOTE: begin
          if (text_byte == (qsingle_r ? 8'h27 : 8'h22)) begin
            v0       = 1'b1;
            rec.tok0 = mk_tok(ttok_pkg::KIND_QUOTED, tstart_r, {1'b0, cur_span}, 1'b1);
            mode_nxt = M_IDLE;
          end
        end
        M_SIGN: begin
          if (is_digit(text_byte)) mode_nxt = M_INT;
          else if (text_byte == ".") mode_nxt = M_SIGNDOT;
          else if (is_op(text_byte)) mode_nxt = M_OP;
          else end_prev = 1'b1;
        end
        M_SIGNDOT, M_DOT: begin
          if (is_digit(text_byte)) mode_nxt = M_FRAC;
          else if (is_op(text_byte)) mode_nxt = M_OP;
          else end_prev = 1'b1;
        end
        M_OP: begin
          if (!is_op(text_byte)) end_prev = 1'b1;
        end
        M_INT, M_FRAC, M_EXP: begin
          if (is_digit(text_byte)) begin
            mode_nxt = mode_r;
          end else if (text_byte == "." && mode_r == M_INT) begin
            mode_nxt = M_FRAC;
          end else if ((text_byte == "e" || text_byte == "E") && mode_r != M_EXP) begin
            mode_nxt = M_EXP;
          end else if (text_byte == "f" || text_byte == "F") begin
            // suffix is part of the token and closes it
            v0       = 1'b1;
            rec.tok0 = mk_tok(ttok_pkg::KIND_NUM, tstart_r,
                              {1'b0, cur_span} + LW'(1), 1'b0);
            mode_nxt = M_IDLE;
          end else begin
            end_prev = 1'b1;
          end
        end
        M_IDENT: begin
          if (!(is_alpha(text_byte) || is_digit(text_byte) || text_byte == "_"))
            end_prev = 1'b1;
        end
        default: begin
          mode_nxt = st.mode;
          if (st.qsel) qsingle_nxt = st.qsingle;
          tstart_nxt = st.tstart;
          if (is_blank(text_byte)) tstart_nxt = tstart_r;
          if (st.emit) begin
            v0       = 1'b1;
            rec.tok0 = mk_tok(st.kind, pos_r,
                              (st.kind == ttok_pkg::KIND_BRACKET) ? LW'(1) : LW'(0), 1'b0);
          end
        end
      endcase

      if (end_prev) begin
        v0       = 1'b1;
        rec.tok0 = mk_tok(kind_of_mode(mode_r), tstart_r, {1'b0, cur_span}, 1'b0);
        mode_nxt = st.mode;
        if (st.qsel) qsingle_nxt = st.qsingle;
        if (!is_blank(text_byte)) tstart_nxt = st.tstart;
        if (st.emit) begin
          v1       = 1'b1;
          rec.tok1 = mk_tok(st.kind, pos_r,
                            (st.kind == ttok_pkg::KIND_BRACKET) ? LW'(1) : LW'(0), 1'b0);
        end
      end
      pos_nxt = sat_inc(pos_r);
    end
    rec.two = v1;
    push    = accept && v0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      qsingle_r <= 1'b0;
      pos_r     <= '0;
      tstart_r  <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      pos_r     <= pos_nxt;
      tstart_r  <= tstart_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ttok_back.sv
// Back end: record queue and output register that sends the tokens of each record one at a time.
`default_nettype none
module ttok_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ttok_pkg::rec_t       rec,
  output      logic                 full,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      ttok_pkg::tok_t       out_tok,
  output      logic                 out_last
);

  localparam int PW = ttok_pkg::QPTR_W;
  localparam int CW = ttok_pkg::QCNT_W;

  ttok_pkg::rec_t q_mem [ttok_pkg::QDEPTH];

  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          sel_r;
  logic          valid_r;
  ttok_pkg::tok_t tok_r;
  logic          last_r;
  logic          load;
  logic          pop;
  logic          head_two;

  assign full      = (count_r == CW'(ttok_pkg::QDEPTH));
  assign load      = (count_r != '0) && (!valid_r || !out_stall);
  assign head_two  = q_mem[rd_ptr_r].two;
  // second token of a record, or a record with one token, retires the entry
  assign pop       = load && (sel_r || !head_two);
  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= rec;
    if (load) begin
      tok_r  <= sel_r ? q_mem[rd_ptr_r].tok1 : q_mem[rd_ptr_r].tok0;
      last_r <= sel_r || !q_mem[rd_ptr_r].two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sel_r    <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
      if (load) sel_r <= !pop;
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ttok_checker.sv
// Port-level assertions for the text tokenizer, bound to the top level.
`default_nettype none
module ttok_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_text_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_token_kind,
  input wire logic [15:0] out_token_start,
  input wire logic [15:0] out_token_length,
  input wire logic        out_quote_closed,
  input wire logic        out_last_of_input
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) &&
      $stable(out_quote_closed) && $stable(out_last_of_input))
    else $error("stalled token changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token valid right after reset");

  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quote_closed |-> out_token_kind == ttok_pkg::KIND_QUOTED)
    else $error("closed flag on non-quoted token");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_kind != ttok_pkg::KIND_BRACKET || out_token_length == 16'd1) &&
      (out_token_kind != ttok_pkg::KIND_EMPTY || out_token_length == 16'd0))
    else $error("bad length for single-byte token");

  // a stalled input word stays on the bus unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_text_byte))
    else $error("stalled input word changed");

endmodule

bind text_tokenizer_unit ttok_checker u_ttok_checker (.*);
`default_nettype wire
